### src/flhg_pkg.sv
// Shared types, constants and helpers for the fan level hysteresis governor.
`timescale 1ns / 1ps

package flhg_pkg;

  localparam int TEMP_BITS_DEF = 8;
  localparam int LIM_W         = 8;
  localparam int LIMITS_W      = 3 * LIM_W;
  localparam int MARGIN_W      = 8;
  localparam int LEVEL_W       = 3;
  localparam int OUT_TDATA_W   = 8;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = LIMITS_W;
  localparam int NUM_BANDS     = 3;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 8'd3;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_CPU_LIMITS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GPU_LIMITS = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MCH_LIMITS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_AUTO_EN    = 3'd4;

  // Fan levels.
  localparam logic [LEVEL_W-1:0] LEVEL_OFF  = 3'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 3'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MID  = 3'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 3'd7;

  typedef enum logic [1:0] {
    BAND_OFF  = 2'd0,
    BAND_LOW  = 2'd1,
    BAND_MID  = 2'd2,
    BAND_HIGH = 2'd3
  } band_t;

  typedef struct packed {
    logic [LIMITS_W-1:0] cpu_limits;
    logic [LIMITS_W-1:0] gpu_limits;
    logic [LIMITS_W-1:0] mch_limits;
    logic [MARGIN_W-1:0] margin;
    logic                auto_en;
  } cfg_t;

  function automatic logic [LEVEL_W-1:0] level_of(input band_t band);
    logic [LEVEL_W-1:0] lvl;
    case (band)
      BAND_OFF:  lvl = LEVEL_OFF;
      BAND_LOW:  lvl = LEVEL_LOW;
      BAND_MID:  lvl = LEVEL_MID;
      BAND_HIGH: lvl = LEVEL_HIGH;
      default:   lvl = LEVEL_OFF;
    endcase
    return lvl;
  endfunction

endpackage

### src/flhg_cfg_regs.sv
// Configuration register file of the fan level governor.
`timescale 1ns / 1ps

module flhg_cfg_regs
  import flhg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpu_limits <= '0;
      cfg_r.gpu_limits <= '0;
      cfg_r.mch_limits <= '0;
      cfg_r.margin     <= MARGIN_RESET;
      cfg_r.auto_en    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CPU_LIMITS: cfg_r.cpu_limits <= cfg_wdata[LIMITS_W-1:0];
        CFG_GPU_LIMITS: cfg_r.gpu_limits <= cfg_wdata[LIMITS_W-1:0];
        CFG_MCH_LIMITS: cfg_r.mch_limits <= cfg_wdata[LIMITS_W-1:0];
        CFG_MARGIN:     cfg_r.margin     <= cfg_wdata[MARGIN_W-1:0];
        CFG_AUTO_EN:    cfg_r.auto_en    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/flhg_sensor.sv
// Per-sensor band tests and hysteresis offset update.
`timescale 1ns / 1ps

module flhg_sensor
  import flhg_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF
) (
  input  logic [TEMP_BITS-1:0] temp,
  input  logic [LIMITS_W-1:0]  limits,
  input  logic [MARGIN_W-1:0]  offset,
  input  logic [MARGIN_W-1:0]  margin,
  input  band_t                band,
  output logic [NUM_BANDS-1:0] below,
  output logic [MARGIN_W-1:0]  offset_nxt
);

  // Two spare bits keep every difference from wrapping.
  localparam int CW = ((TEMP_BITS > LIM_W) ? TEMP_BITS : LIM_W) + 2;

  logic signed [CW-1:0] t_s;
  logic signed [CW-1:0] off_s;
  logic signed [CW-1:0] mrg_s;
  logic signed [CW-1:0] lim_s [NUM_BANDS];
  logic signed [CW-1:0] low_s;

  assign t_s   = $signed({{(CW-TEMP_BITS){1'b0}}, temp});
  assign off_s = $signed({{(CW-MARGIN_W){1'b0}}, offset});
  assign mrg_s = $signed({{(CW-MARGIN_W){1'b0}}, margin});

  always_comb begin
    for (int b = 0; b < NUM_BANDS; b++) begin
      lim_s[b] = $signed({{(CW-LIM_W){1'b0}}, limits[LIM_W*b +: LIM_W]});
      below[b] = t_s < (lim_s[b] - off_s);
    end
  end

  // Lower limit of the chosen band.
  always_comb begin
    case (band)
      BAND_LOW:  low_s = lim_s[0];
      BAND_MID:  low_s = lim_s[1];
      BAND_HIGH: low_s = lim_s[2];
      default:   low_s = '0;
    endcase
  end

  always_comb begin
    if (band == BAND_OFF) begin
      offset_nxt = offset;
    end else if (t_s == low_s) begin
      offset_nxt = margin;
    end else if (t_s <= (low_s - mrg_s)) begin
      offset_nxt = '0;
    end else begin
      offset_nxt = offset;
    end
  end

endmodule

### src/fan_level_hysteresis_governor.sv
// Fan level governor: picks a fan level from three temperatures with hysteresis.
// Accepted sample words wait in the input register; each result word is then
// written to the result register. One sample word per cycle unless the result
// stalls; one stage of band compare and offset update logic parts the registers.
// With auto mode off, accepted samples give no result and offsets are kept.
// Reset (rst_n low, synchronous) empties both registers and restores defaults.
`timescale 1ns / 1ps

module fan_level_hysteresis_governor
  import flhg_pkg::*;
#(
  parameter int TEMP_BITS = TEMP_BITS_DEF,
  localparam int IN_TDATA_W = ((3 * TEMP_BITS + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: cpu_temp, gpu_temp, mch_temp, zero padding.
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: fan_level, zero padding.
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg;

  logic                  in_valid_r;
  logic [TEMP_BITS-1:0]  cpu_temp_r, gpu_temp_r, mch_temp_r;
  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    level_r;
  logic [MARGIN_W-1:0]   cpu_off_r, gpu_off_r, mch_off_r;
  logic [MARGIN_W-1:0]   cpu_off_nxt, gpu_off_nxt, mch_off_nxt;
  logic [NUM_BANDS-1:0]  cpu_below, gpu_below, mch_below, all_below;
  band_t                 band;
  logic                  in_take;
  logic                  advance;
  logic                  emit;

  flhg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  flhg_sensor #(.TEMP_BITS(TEMP_BITS)) u_cpu (
    .temp (cpu_temp_r), .limits (cfg.cpu_limits), .offset (cpu_off_r),
    .margin (cfg.margin), .band (band), .below (cpu_below), .offset_nxt (cpu_off_nxt)
  );

  flhg_sensor #(.TEMP_BITS(TEMP_BITS)) u_gpu (
    .temp (gpu_temp_r), .limits (cfg.gpu_limits), .offset (gpu_off_r),
    .margin (cfg.margin), .band (band), .below (gpu_below), .offset_nxt (gpu_off_nxt)
  );

  flhg_sensor #(.TEMP_BITS(TEMP_BITS)) u_mch (
    .temp (mch_temp_r), .limits (cfg.mch_limits), .offset (mch_off_r),
    .margin (cfg.margin), .band (band), .below (mch_below), .offset_nxt (mch_off_nxt)
  );

  assign all_below = cpu_below & gpu_below & mch_below;

  always_comb begin
    if (all_below[0]) begin
      band = BAND_OFF;
    end else if (all_below[1]) begin
      band = BAND_LOW;
    end else if (all_below[2]) begin
      band = BAND_MID;
    end else begin
      band = BAND_HIGH;
    end
  end

  // A sample leaves the input register when it is dropped (auto off) or
  // when the result register is free or being emptied in this cycle.
  assign advance   = in_valid_r && (!cfg.auto_en || !out_valid_r || out_tready);
  assign emit      = advance && cfg.auto_en;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cpu_off_r   <= '0;
      gpu_off_r   <= '0;
      mch_off_r   <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
        cpu_off_r   <= cpu_off_nxt;
        gpu_off_r   <= gpu_off_nxt;
        mch_off_r   <= mch_off_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cpu_temp_r <= in_tdata[0*TEMP_BITS +: TEMP_BITS];
      gpu_temp_r <= in_tdata[1*TEMP_BITS +: TEMP_BITS];
      mch_temp_r <= in_tdata[2*TEMP_BITS +: TEMP_BITS];
    end
    if (emit) begin
      level_r <= level_of(band);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-LEVEL_W){1'b0}}, level_r};

endmodule

### src/flhg_checker.sv
// Port-level checks for the fan level governor, bound to the top level.
`timescale 1ns / 1ps

module flhg_checker
  import flhg_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // A stalled result word keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Only levels 0, 1, 5 and 7 are ever produced, with zero padding above.
  a_level_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == OUT_TDATA_W'(LEVEL_OFF) ||
                    out_tdata == OUT_TDATA_W'(LEVEL_LOW) ||
                    out_tdata == OUT_TDATA_W'(LEVEL_MID) ||
                    out_tdata == OUT_TDATA_W'(LEVEL_HIGH)))
    else $error("illegal fan level on output");

  // An empty result register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register empty");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind fan_level_hysteresis_governor flhg_checker u_flhg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### bench/fan_level_hysteresis_governor_tb.sv
// Self-checking testbench for the fan level hysteresis governor.
`timescale 1ns / 1ps

module fan_level_hysteresis_governor_tb;
  import flhg_pkg::*;

  localparam int TEMP_W       = TEMP_BITS_DEF;
  localparam int IN_W         = ((3 * TEMP_BITS_DEF + 7) / 8) * 8;
  localparam int PIPE_LATENCY = 2;
  localparam int GAP_MAX      = 14;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 60;

  // Predicts the fan level for every accepted sample word and checks the
  // result words against those predictions in order.
  class fan_level_scoreboard;
    logic [LIMITS_W-1:0] cpu_lim, gpu_lim, mch_lim;
    logic [MARGIN_W-1:0] margin;
    logic                auto_en;
    logic [MARGIN_W-1:0] cpu_off, gpu_off, mch_off;
    logic [LEVEL_W-1:0]  expected_levels[$];
    int                  mismatches;

    function new();
      cpu_lim    = '0;
      gpu_lim    = '0;
      mch_lim    = '0;
      margin     = MARGIN_RESET;
      auto_en    = 1'b0;
      cpu_off    = '0;
      gpu_off    = '0;
      mch_off    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        CFG_CPU_LIMITS: cpu_lim = data;
        CFG_GPU_LIMITS: gpu_lim = data;
        CFG_MCH_LIMITS: mch_lim = data;
        CFG_MARGIN:     margin  = data[MARGIN_W-1:0];
        CFG_AUTO_EN:    auto_en = data[0];
        default: ;
      endcase
    endfunction

    function bit under_limit(int t, logic [LIMITS_W-1:0] lims, int band,
                             logic [MARGIN_W-1:0] off);
      int lim;
      int o;
      lim = int'(lims[LIM_W*band +: LIM_W]);
      o   = int'(off);
      return t < lim - o;
    endfunction

    function logic [MARGIN_W-1:0] next_offset(int t, logic [LIMITS_W-1:0] lims, int band,
                                              logic [MARGIN_W-1:0] off);
      int lim;
      int m;
      lim = int'(lims[LIM_W*band +: LIM_W]);
      m   = int'(margin);
      if (t == lim) return margin;
      if (t <= lim - m) return '0;
      return off;
    endfunction

    function void note_sample(logic [IN_W-1:0] word);
      int t_cpu, t_gpu, t_mch;
      int band;
      logic [LEVEL_W-1:0] level;
      t_cpu = int'(word[0 +: TEMP_W]);
      t_gpu = int'(word[TEMP_W +: TEMP_W]);
      t_mch = int'(word[2*TEMP_W +: TEMP_W]);
      if (!auto_en) return;
      for (band = 0; band < NUM_BANDS; band++) begin
        if (under_limit(t_cpu, cpu_lim, band, cpu_off) &&
            under_limit(t_gpu, gpu_lim, band, gpu_off) &&
            under_limit(t_mch, mch_lim, band, mch_off))
          break;
      end
      case (band)
        0:       level = LEVEL_OFF;
        1:       level = LEVEL_LOW;
        2:       level = LEVEL_MID;
        default: level = LEVEL_HIGH;
      endcase
      // The offsets track the lower limit of the band that was picked.
      if (band > 0) begin
        cpu_off = next_offset(t_cpu, cpu_lim, band - 1, cpu_off);
        gpu_off = next_offset(t_gpu, gpu_lim, band - 1, gpu_off);
        mch_off = next_offset(t_mch, mch_lim, band - 1, mch_off);
      end
      expected_levels.push_back(level);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] word);
      logic [LEVEL_W-1:0] level;
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %0d", $time, word);
        mismatches++;
        return;
      end
      level = expected_levels.pop_front();
      if (word[LEVEL_W-1:0] !== level) begin
        $display("%0t: fan_level mismatch: expected %0d, got %0d",
                 $time, level, word[LEVEL_W-1:0]);
        mismatches++;
      end
      if (word[OUT_TDATA_W-1:LEVEL_W] !== '0) begin
        $display("%0t: result padding mismatch: expected 0, got %0h",
                 $time, word[OUT_TDATA_W-1:LEVEL_W]);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  fan_level_scoreboard book = new();
  bit quick_mode = 1'b0;
  int hold_request = 0;
  int idle_cycles = 0;

  fan_level_hysteresis_governor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: random stalls, with an occasional long hold-off on request.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = quick_mode ? 0 : $urandom_range(0, GAP_MAX);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      book.check_result(out_tdata);
    end
  end

  function automatic logic [IN_W-1:0] sample_word(logic [7:0] c, logic [7:0] g, logic [7:0] m);
    return {m, g, c};
  endfunction

  function automatic logic [LIMITS_W-1:0] rand_limits();
    logic [7:0] a, b, c, t;
    a = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return LIMITS_W'($urandom);
      default: begin
        if (a > b) begin t = a; a = b; b = t; end
        if (b > c) begin t = b; b = c; c = t; end
        if (a > b) begin t = a; a = b; b = t; end
        return {c, b, a};
      end
    endcase
  endfunction

  // Temperatures mostly sit on or near a limit, or drift from the last one,
  // so the hysteresis offsets get set and cleared often.
  function automatic logic [7:0] rand_temp(logic [LIMITS_W-1:0] lims, logic [MARGIN_W-1:0] marg,
                                           logic [7:0] prev);
    int band;
    int lim;
    int t;
    band = $urandom_range(0, 2);
    lim  = int'(lims[LIM_W*band +: LIM_W]);
    case ($urandom_range(0, 6))
      0:       t = $urandom_range(0, 255);
      1:       t = lim;
      2:       t = lim - int'(marg);
      3:       t = lim + int'($urandom_range(0, 6)) - 3;
      4:       t = $urandom_range(0, 1) ? 255 : 0;
      5:       t = lim - int'($urandom_range(0, int'(marg) + 2));
      default: t = int'(prev) + int'($urandom_range(0, 4)) - 2;
    endcase
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  task automatic write_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    book.write_reg(addr, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Bits above each register's width carry junk; the block must ignore them.
  task automatic apply_settings(logic [LIMITS_W-1:0] c, logic [LIMITS_W-1:0] g,
                                logic [LIMITS_W-1:0] m, logic [MARGIN_W-1:0] marg,
                                logic auto_on);
    write_cfg(CFG_CPU_LIMITS, c);
    write_cfg(CFG_GPU_LIMITS, g);
    write_cfg(CFG_MCH_LIMITS, m);
    write_cfg(CFG_MARGIN, CFG_DATA_W'(($urandom & ~32'hFF) | 32'(marg)));
    write_cfg(CFG_AUTO_EN, CFG_DATA_W'(($urandom & ~32'h1) | 32'(auto_on)));
  endtask

  task automatic send_sample(logic [IN_W-1:0] word);
    int gap;
    gap = quick_mode ? 0 : $urandom_range(0, GAP_MAX);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = word;
    do @(posedge clk); while (!in_tready);
    book.note_sample(word);
  endtask

  // Waits until every predicted word is back and the pipeline has emptied.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  initial begin
    logic [LIMITS_W-1:0] lims[3];
    logic [MARGIN_W-1:0] marg;
    logic [7:0]          prev[3];
    logic                auto_on;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    prev       = '{default: '0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Auto mode is off after reset, so these give no result.
    send_sample(sample_word(8'd255, 8'd255, 8'd255));
    send_sample(sample_word(8'd0, 8'd0, 8'd0));
    settle();

    apply_settings(24'h3C3228, 24'h463C32, 24'h50463C, 8'd3, 1'b1);
    send_sample(sample_word(8'd0, 8'd0, 8'd0));
    send_sample(sample_word(8'd40, 8'd0, 8'd0));     // hits cpu min, offset loads
    send_sample(sample_word(8'd39, 8'd0, 8'd0));     // held up by the offset
    send_sample(sample_word(8'd37, 8'd0, 8'd0));     // at min minus margin, offset clears
    send_sample(sample_word(8'd36, 8'd0, 8'd0));
    send_sample(sample_word(8'd50, 8'd60, 8'd70));   // all sensors on their mid limit
    send_sample(sample_word(8'd49, 8'd59, 8'd69));
    send_sample(sample_word(8'd255, 8'd255, 8'd255));
    send_sample(sample_word(8'd60, 8'd70, 8'd80));   // all sensors on their max limit
    send_sample(sample_word(8'd0, 8'd0, 8'd0));      // band zero keeps the offsets
    settle();

    // A margin above every limit: the clear test can never pass.
    apply_settings(24'h3C3228, 24'h463C32, 24'h50463C, 8'd255, 1'b1);
    send_sample(sample_word(8'd45, 8'd0, 8'd0));
    send_sample(sample_word(8'd40, 8'd0, 8'd0));
    send_sample(sample_word(8'd0, 8'd0, 8'd0));
    settle();

    // Limits out of order and at both extremes, with a zero margin.
    apply_settings(24'h0AC864, 24'hFFFFFF, 24'h000000, 8'd0, 1'b1);
    send_sample(sample_word(8'd100, 8'd255, 8'd0));
    send_sample(sample_word(8'd200, 8'd254, 8'd255));
    send_sample(sample_word(8'd5, 8'd128, 8'd0));
    settle();

    // Writes to indexes past the register list must change nothing.
    for (int a = CFG_AUTO_EN + 1; a < (1 << CFG_ADDR_W); a++)
      write_cfg(a[CFG_ADDR_W-1:0], CFG_DATA_W'($urandom));
    send_sample(sample_word(8'd100, 8'd255, 8'd0));
    settle();

    apply_settings('0, '0, '0, MARGIN_RESET, 1'b0);
    send_sample(sample_word(8'd0, 8'd0, 8'd0));
    send_sample(sample_word(8'd255, 8'd255, 8'd255));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      quick_mode = (p % 4 == 2);
      for (int s = 0; s < 3; s++)
        lims[s] = rand_limits();
      case ($urandom_range(0, 5))
        0:       marg = '0;
        1:       marg = '1;
        2:       marg = MARGIN_W'($urandom_range(0, 255));
        default: marg = MARGIN_W'($urandom_range(1, 6));
      endcase
      auto_on = ($urandom_range(0, 5) != 0) || (p < 4);
      apply_settings(lims[0], lims[1], lims[2], marg, auto_on);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Long receiver hold-off while samples keep coming in.
        if (p == 2 && i == 10)
          hold_request = HOLD_CYCLES;
        if ((p == 5 && i == 30) || $urandom_range(0, 63) == 0)
          settle();
        for (int s = 0; s < 3; s++)
          prev[s] = rand_temp(lims[s], marg, prev[s]);
        send_sample(sample_word(prev[0], prev[1], prev[2]));
      end
      settle();
    end
    quick_mode = 1'b0;

    if (book.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
